[rtl/dpis_pkg.sv]
// shared types, codes and frame constants for the popup text sender
package dpis_pkg;

    localparam int SLOT_CHARS = 4;
    localparam int NUM_SLOTS  = 3;
    localparam int LEN_W      = 3;
    localparam int ID_W       = 11;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT_FC = 2'd1,
        PH_FRAME1  = 2'd2,
        PH_FRAME2  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_RX   = 2'd1,
        CMD_SEND = 2'd2,
        CMD_LOAD = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_FC_TIMEOUT = 2'd0,
        CFG_INHIBIT    = 2'd1,
        CFG_FC_ID      = 2'd2,
        CFG_DISPLAY_ID = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] SLOT_LEFT   = 2'd0;
    localparam logic [1:0] SLOT_CENTER = 2'd1;
    localparam logic [1:0] SLOT_RIGHT  = 2'd2;
    localparam logic [1:0] SLOT_NONE   = 2'd3;

    localparam logic [7:0] PCI_FIRST   = 8'h10;
    localparam logic [7:0] PCI_CF1     = 8'h21;
    localparam logic [7:0] PCI_CF2     = 8'h22;
    localparam logic [7:0] FF_BYTE2    = 8'h40;
    localparam logic [7:0] FF_BYTE5    = 8'h0A;
    localparam logic [7:0] FF_LEN_OFS  = 8'h06;
    localparam logic [7:0] FF_SUB_OFS  = 8'h03;
    localparam logic [7:0] TYPE_LEFT   = 8'hA3;
    localparam logic [7:0] TYPE_CENTER = 8'hA4;
    localparam logic [7:0] TYPE_RIGHT  = 8'hA5;
    localparam logic [7:0] PAD_BYTE    = 8'hCC;
    localparam logic [7:0] FC_CONTINUE = 8'h30;

    localparam logic [MS_W-1:0] RST_FC_TIMEOUT = 16'd1000;
    localparam logic [MS_W-1:0] RST_INHIBIT    = 16'd50;
    localparam logic [ID_W-1:0] RST_FC_ID      = 11'h2C8;
    localparam logic [ID_W-1:0] RST_DISPLAY_ID = 11'h6C8;

    typedef struct packed {
        logic        sent;
        logic        done;
        t_phase      next_phase;
        logic [63:0] payload;
    } t_frame_res;

    typedef struct packed {
        logic        frame_valid;
        logic [63:0] payload;
        t_phase      state;
    } t_result;

    function automatic logic [7:0] slot_type(input logic [1:0] s);
        logic [7:0] t;
        case (s)
            SLOT_CENTER: t = TYPE_CENTER;
            SLOT_RIGHT:  t = TYPE_RIGHT;
            default:     t = TYPE_LEFT;
        endcase
        return t;
    endfunction

endpackage

[rtl/dpis_frame.sv]
// frame builder for one send pass on the current slot
module dpis_frame (
    input  dpis_pkg::t_phase           i_phase,
    input  logic [dpis_pkg::LEN_W-1:0] i_len,
    input  logic [31:0]                i_text,
    input  logic [1:0]                 i_slot,
    input  logic                       i_fc_expired,
    output dpis_pkg::t_frame_res       o_res
);
    import dpis_pkg::*;

    logic [7:0] b [8];
    logic [7:0] len2;

    assign len2 = {4'd0, i_len, 1'b0};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            b[i] = 8'd0;
        end
        o_res.sent       = 1'b0;
        o_res.done       = 1'b0;
        o_res.next_phase = i_phase;
        if (i_len != '0) begin
            unique case (i_phase)
                PH_IDLE: begin
                    b[0] = PCI_FIRST;
                    b[1] = FF_LEN_OFS + len2;
                    b[2] = FF_BYTE2;
                    b[4] = FF_SUB_OFS + len2;
                    b[5] = FF_BYTE5;
                    b[6] = slot_type(i_slot);
                    b[7] = {5'd0, i_len};
                    o_res.sent       = 1'b1;
                    o_res.next_phase = PH_WAIT_FC;
                end
                PH_WAIT_FC: begin
                    if (i_fc_expired) begin
                        o_res.next_phase = PH_IDLE;
                    end
                end
                PH_FRAME1: begin
                    b[0] = PCI_CF1;
                    if (i_len > 3'd0) b[2] = i_text[7:0];
                    if (i_len > 3'd1) b[4] = i_text[15:8];
                    if (i_len > 3'd2) b[6] = i_text[23:16];
                    o_res.sent = 1'b1;
                    if (i_len > 3'd3) begin
                        o_res.next_phase = PH_FRAME2;
                    end else begin
                        o_res.done       = 1'b1;
                        o_res.next_phase = PH_IDLE;
                    end
                end
                PH_FRAME2: begin
                    b[0] = PCI_CF2;
                    if (i_len > 3'd3) begin
                        b[1] = i_text[31:24];
                        for (int i = 2; i < 8; i++) begin
                            b[i] = PAD_BYTE;
                        end
                    end
                    o_res.sent       = 1'b1;
                    o_res.done       = 1'b1;
                    o_res.next_phase = PH_IDLE;
                end
                default: o_res.next_phase = i_phase;
            endcase
        end
        o_res.payload = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    end

endmodule

[rtl/dpis_out.sv]
// result register between the step logic and the output channel
module dpis_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dpis_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output dpis_pkg::t_result o_res
);
    import dpis_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_res.frame_valid |-> r_res.payload == 64'd0)
        else $error("idle result carries a payload");

    a_frame_pci: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.frame_valid |->
            (r_res.payload[63:56] == PCI_FIRST || r_res.payload[63:56] == PCI_CF1
             || r_res.payload[63:56] == PCI_CF2))
        else $error("frame without a valid protocol control byte");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_res))
        else $error("result changed while stalled");

endmodule

[rtl/display_popup_isotp_sender.sv]
// top level: popup text sender with request register, sender state and result register
//
// Usage: one request enters on the input channel (i_in_valid / o_in_ready) and carries a
// command: millisecond tick, received frame, send pass or text slot load. Every request
// gives exactly one result on the output channel (o_out_valid / i_out_ready): a frame
// flag, the eight frame bytes and the sender state after the request.
// The request waits in the request register until the result register is free, and its
// result is then registered there. Throughput is one request per cycle while results are
// taken; the state update is a single short pass between the two registers.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user must
// make them only while no request is in flight, as the block does not enforce this.
// Reset empties both registers, clears all text slots, sets the sender idle on the left
// slot, zeroes both millisecond counters and restores the register reset values.
// When the receiver stalls, the result holds and the request register still takes one
// more request; after that o_in_ready falls until the result is taken.
module display_popup_isotp_sender (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dpis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [dpis_pkg::ID_W-1:0]       i_rx_frame_id,
    input  logic [7:0]                      i_rx_first_byte,
    input  logic [1:0]                      i_slot_select,
    input  logic [31:0]                     i_slot_chars,
    input  logic [dpis_pkg::LEN_W-1:0]      i_slot_length,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_frame_valid,
    output logic [63:0]                     o_frame_payload,
    output logic [1:0]                      o_sender_state
);
    import dpis_pkg::*;

    // configuration
    logic [MS_W-1:0] r_fc_timeout;
    logic [MS_W-1:0] r_inhibit;
    logic [ID_W-1:0] r_fc_id;
    logic [ID_W-1:0] r_display_id;

    // request register
    logic             r_in_valid;
    t_cmd             r_cmd;
    logic [ID_W-1:0]  r_rx_id;
    logic [7:0]       r_rx_b0;
    logic [1:0]       r_sel;
    logic [31:0]      r_chars;
    logic [LEN_W-1:0] r_slen;

    // sender state
    t_phase           r_phase,    n_phase;
    logic [1:0]       r_cur_slot, n_cur_slot;
    logic [31:0]      r_slot_text [NUM_SLOTS];
    logic [31:0]      n_slot_text [NUM_SLOTS];
    logic [LEN_W-1:0] r_slot_len  [NUM_SLOTS];
    logic [LEN_W-1:0] n_slot_len  [NUM_SLOTS];
    logic [MS_W-1:0]  r_fc_ms,    n_fc_ms;
    logic [MS_W-1:0]  r_quiet_ms, n_quiet_ms;

    logic       advance;
    logic       out_free;
    logic [1:0] s;
    t_frame_res frame;
    t_result    n_res;
    t_result    out_res;

    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc_timeout <= RST_FC_TIMEOUT;
            r_inhibit    <= RST_INHIBIT;
            r_fc_id      <= RST_FC_ID;
            r_display_id <= RST_DISPLAY_ID;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FC_TIMEOUT: r_fc_timeout <= i_cfg_data;
                CFG_INHIBIT:    r_inhibit    <= i_cfg_data;
                CFG_FC_ID:      r_fc_id      <= i_cfg_data[ID_W-1:0];
                CFG_DISPLAY_ID: r_display_id <= i_cfg_data[ID_W-1:0];
                default:        r_fc_timeout <= r_fc_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_rx_id <= i_rx_frame_id;
            r_rx_b0 <= i_rx_first_byte;
            r_sel   <= i_slot_select;
            r_chars <= i_slot_chars;
            r_slen  <= i_slot_length;
        end
    end

    assign s = (r_cur_slot == SLOT_NONE) ? SLOT_LEFT : r_cur_slot;

    dpis_frame u_frame (
        .i_phase      (r_phase),
        .i_len        (r_slot_len[s]),
        .i_text       (r_slot_text[s]),
        .i_slot       (s),
        .i_fc_expired (r_fc_ms >= r_fc_timeout),
        .o_res        (frame)
    );

    always_comb begin
        n_phase    = r_phase;
        n_cur_slot = r_cur_slot;
        n_fc_ms    = r_fc_ms;
        n_quiet_ms = r_quiet_ms;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_slot_text[i] = r_slot_text[i];
            n_slot_len[i]  = r_slot_len[i];
        end
        n_res.frame_valid = 1'b0;
        n_res.payload     = 64'd0;
        unique case (r_cmd)
            CMD_TICK: begin
                if (r_fc_ms != '1) n_fc_ms = r_fc_ms + MS_W'(1);
                if (r_quiet_ms != '1) n_quiet_ms = r_quiet_ms + MS_W'(1);
            end
            CMD_RX: begin
                if (r_phase == PH_WAIT_FC && r_rx_id == r_fc_id) begin
                    n_phase = (r_rx_b0 == FC_CONTINUE) ? PH_FRAME1 : PH_IDLE;
                end
                if (r_rx_id == r_display_id) n_quiet_ms = '0;
            end
            CMD_SEND: begin
                if (r_quiet_ms < r_inhibit) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = frame.next_phase;
                    if (frame.sent && r_phase == PH_IDLE) n_fc_ms = '0;
                    if (frame.done) begin
                        n_slot_text[s] = '0;
                        n_slot_len[s]  = '0;
                    end
                    n_res.frame_valid = frame.sent;
                    n_res.payload     = frame.sent ? frame.payload : 64'd0;
                    if (frame.next_phase == PH_IDLE) begin
                        n_cur_slot = (s == SLOT_RIGHT) ? SLOT_LEFT : s + 2'd1;
                    end else begin
                        n_cur_slot = s;
                    end
                end
            end
            CMD_LOAD: begin
                if (r_sel != SLOT_NONE) begin
                    n_slot_text[r_sel] = r_chars;
                    n_slot_len[r_sel]  = (r_slen > LEN_W'(SLOT_CHARS)) ?
                                         LEN_W'(SLOT_CHARS) : r_slen;
                end
            end
            default: n_phase = r_phase;
        endcase
        n_res.state = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cur_slot <= SLOT_LEFT;
            r_fc_ms    <= '0;
            r_quiet_ms <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_text[i] <= '0;
                r_slot_len[i]  <= '0;
            end
        end else if (advance) begin
            r_phase    <= n_phase;
            r_cur_slot <= n_cur_slot;
            r_fc_ms    <= n_fc_ms;
            r_quiet_ms <= n_quiet_ms;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_text[i] <= n_slot_text[i];
                r_slot_len[i]  <= n_slot_len[i];
            end
        end
    end

    dpis_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (n_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_frame_valid   = out_res.frame_valid;
    assign o_frame_payload = out_res.payload;
    assign o_sender_state  = out_res.state;

    a_slot_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_slot != SLOT_NONE)
        else $error("current slot left the three slot range");

    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_sender_state == r_phase)
        else $error("reported state differs from sender state");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_len[0] <= LEN_W'(SLOT_CHARS) && r_slot_len[1] <= LEN_W'(SLOT_CHARS)
        && r_slot_len[2] <= LEN_W'(SLOT_CHARS))
        else $error("slot length above limit");

endmodule
